// ===== hdl/sil_pkg.sv =====
// Package for the sorted insert list: depth, derived widths and the sweep state type.
// No dependencies; used by sil_ram users and the top level.
`timescale 1ns / 1ps

package sil_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_SWEEP
    } state_t;

endpackage

// ===== hdl/sil_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sil_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sorted_insert_list.sv =====
// Sorted insert list: keeps up to DEPTH signed values ascending in one RAM.
// Start moves state_reg into the sweep, then results leave strobe_reg, one result per cycle.
// An insert into n entries holds busy high over a single pass of min(n+1, DEPTH) entries,
// reading one entry per cycle and writing from the insert point on; busy blocks a new start.
// Reset empties the list at once (count to zero); RAM contents are not cleared.
// Results are strobed for one cycle each; the receiver cannot stall them.
`timescale 1ns / 1ps

module sorted_insert_list (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sil_pkg::DATA_W-1:0]  value,
    output logic                               strobe,
    output logic signed [sil_pkg::DATA_W-1:0]  sorted_value,
    output logic        [sil_pkg::POS_W-1:0]   position,
    output logic                               last,
    output logic                               overflow
);

    import sil_pkg::*;

    // Sweep control
    state_t state_reg, state_next;
    addr_t  idx_reg, idx_next;          // entry handled this cycle
    addr_t  last_idx_reg, last_idx_next; // final position of the new listing
    cnt_t   count_reg, count_next;       // entries stored before this insert
    logic   full_reg, full_next;         // list was full: the largest gets dropped
    logic   ins_reg, ins_next;           // new value already placed

    // Payload held through the sweep
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] carry_reg, carry_next; // value pushed one slot up

    // Result register
    logic                     strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    addr_t                    out_idx_reg, out_idx_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_ovf_reg, out_ovf_next;

    // RAM ports
    logic                     ram_we;
    addr_t                    ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    addr_t                    ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] stored;

    logic in_old;
    logic accept;

    sil_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stored = ram_rdata;
    assign busy   = (state_reg == ST_SWEEP);
    assign accept = start && !busy;
    // Entry at idx exists in the old list; otherwise this is the appended slot.
    assign in_old = (CNT_W'(idx_reg) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        last_idx_reg  <= last_idx_next;
        full_reg      <= full_next;
        ins_reg       <= ins_next;
        value_reg     <= value_next;
        carry_reg     <= carry_next;
        out_value_reg <= out_value_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        count_next     = count_reg;
        full_next      = full_reg;
        ins_next       = ins_reg;
        value_next     = value_reg;
        carry_next     = carry_reg;
        strobe_next    = 1'b0;
        out_value_next = out_value_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = carry_reg;
        ram_raddr      = idx_reg + addr_t'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                // Fetch entry 0 while capturing the transfer.
                ram_raddr = '0;
                if (accept)
                begin
                    state_next = ST_SWEEP;
                    idx_next   = '0;
                    value_next = value;
                    carry_next = value;
                    ins_next   = 1'b0;
                    full_next  = (count_reg == cnt_t'(DEPTH));
                    if (count_reg == cnt_t'(DEPTH))
                    begin
                        last_idx_next = addr_t'(DEPTH - 1);
                    end
                    else
                    begin
                        last_idx_next = addr_t'(count_reg);
                    end
                end
            end

            ST_SWEEP:
            begin
                strobe_next   = 1'b1;
                out_idx_next  = idx_reg;
                out_last_next = (idx_reg == last_idx_reg);
                out_ovf_next  = full_reg;
                if (in_old)
                begin
                    if (!ins_reg && (stored > value_reg))
                    begin
                        // Place the new value here and push the old one up.
                        out_value_next = value_reg;
                        ram_we         = 1'b1;
                        ram_wdata      = value_reg;
                        carry_next     = stored;
                        ins_next       = 1'b1;
                    end
                    else if (ins_reg)
                    begin
                        out_value_next = carry_reg;
                        ram_we         = 1'b1;
                        ram_wdata      = carry_reg;
                        carry_next     = stored;
                    end
                    else
                    begin
                        out_value_next = stored;
                    end
                end
                else
                begin
                    // Appended slot: the new value or the last pushed entry.
                    out_value_next = carry_reg;
                    ram_we         = 1'b1;
                    ram_wdata      = carry_reg;
                end

                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_IDLE;
                    count_next = CNT_W'(last_idx_reg) + cnt_t'(1);
                end
                else
                begin
                    idx_next = idx_reg + addr_t'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign strobe       = strobe_reg;
    assign sorted_value = out_value_reg;
    assign position     = POS_W'(out_idx_reg);
    assign last         = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ===== tb/sorted_insert_list_test.sv =====
`timescale 1ns / 1ps
// Testbench for sorted_insert_list: directed and random inserts, each listing checked
// entry by entry against an in-bench model of the sorted list. Depends on sil_pkg.

module sorted_insert_list_test;
    import sil_pkg::*;

    localparam int CLK_PERIOD  = 12;
    // The limit lies well above the slowest correct run (long gaps plus a full sweep per insert).
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t VAL_MIN = 32'sh8000_0000;
    localparam word_t VAL_MAX = 32'sh7FFF_FFFF;

    // One listed value, as the block should strobe it.
    typedef struct packed {
        word_t            sorted_value;
        logic [POS_W-1:0] position;
        logic             last;
        logic             overflow;
    } listing_entry_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    word_t                value = '0;
    logic                 busy;
    logic                 strobe;
    word_t                sorted_value;
    logic [POS_W-1:0]     position;
    logic                 last;
    logic                 overflow;

    // Model of the list contents, kept in step with every accepted transfer.
    word_t                model_list [DEPTH];
    int                   model_count = 0;
    listing_entry_t       expected_listing [$];

    int                   error_count       = 0;
    int                   insert_count      = 0;
    int                   result_count      = 0;
    int                   overflow_listings = 0;
    int                   cycle_count       = 0;
    bit                   idle_enabled      = 1'b0;

    sorted_insert_list u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .position     (position),
        .last         (last),
        .overflow     (overflow)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Insert v into the model list and queue the full listing it causes.
    // A full list keeps its DEPTH smallest values; a value not below the current
    // largest is the one that falls off, leaving the list as it was.
    function automatic void predict_insert(input word_t v);
        int             i;
        int             slot;
        bit             dropped;
        listing_entry_t entry;
        slot    = model_count;
        dropped = 1'b0;
        // equal values stay ahead of the new one: stop only on strictly greater
        for (i = 0; i < model_count; i++)
        begin
            if (model_list[i] > v)
            begin
                slot = i;
                break;
            end
        end
        if (model_count == DEPTH)
        begin
            dropped = 1'b1;
            if (slot < DEPTH)
            begin
                for (i = DEPTH - 1; i > slot; i--)
                    model_list[i] = model_list[i - 1];
                model_list[slot] = v;
            end
        end
        else
        begin
            for (i = model_count; i > slot; i--)
                model_list[i] = model_list[i - 1];
            model_list[slot] = v;
            model_count++;
        end
        if (dropped)
            overflow_listings++;
        for (i = 0; i < model_count; i++)
        begin
            entry.sorted_value = model_list[i];
            entry.position     = POS_W'(i);
            entry.last         = (i == model_count - 1);
            entry.overflow     = dropped;
            expected_listing.push_back(entry);
        end
    endfunction

    // No gap or a short one in most cases, now and then a long one that outlasts a sweep.
    function automatic int pick_gap();
        int roll;
        if (!idle_enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 4);
        else if (roll < 95)
            return $urandom_range(5, 18);
        else
            return $urandom_range(19, 60);
    endfunction

    // Pick a value that lands somewhere useful once the list is full: ties with
    // stored entries, neighbors of them, the edge of the largest, field extremes and plain noise.
    function automatic word_t pick_value();
        int    roll;
        word_t base;
        if (model_count == 0)
            return word_t'($urandom);
        roll = $urandom_range(0, 99);
        base = model_list[$urandom_range(0, model_count - 1)];
        if (roll < 30)
            return word_t'($urandom);
        else if (roll < 55)
            return base;
        else if (roll < 78)
            return base + word_t'($urandom_range(0, 6)) - 3;
        else if (roll < 90)
            return model_list[model_count - 1] + word_t'($urandom_range(0, 2)) - 1;
        else
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
    endfunction

    // Present one value and hold it until the block takes the transfer.
    // With no gap, start stays high straight from the previous transfer.
    task automatic send_value(input word_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_insert(v);
        insert_count++;
    endtask

    // Fill the empty list with the field extremes, ties and spread values.
    task automatic test_fill_and_extremes();
        word_t fill [16];
        int    i;
        fill = '{32'sd0, VAL_MIN, VAL_MAX, -32'sd1, 32'sd1, 32'sd0, VAL_MIN, VAL_MAX,
                 32'sd7, -32'sd7, 32'sd7, 32'sd1000, -32'sd1000, 32'sh4000_0000,
                 32'shC000_0000, 32'sd2};
        idle_enabled = 1'b1;
        for (i = 0; i < 16 && i < DEPTH; i++)
            send_value(fill[i]);
    endtask

    // Drive the full list through each drop case, back to back.
    task automatic test_full_list_drops();
        idle_enabled = 1'b0;
        send_value(VAL_MAX);    // ties the largest: new value falls off
        send_value(VAL_MAX);
        send_value(VAL_MIN);    // lands after the stored minimums, largest falls off
        send_value(VAL_MIN);    // lands after the stored minimums
        send_value(32'sd7);     // ties an entry in the middle
        send_value(-32'sd1);
    endtask

    // Random inserts with idle gaps landing on every phase of the sweep.
    task automatic test_random_with_gaps(input int count);
        int i;
        idle_enabled = 1'b1;
        for (i = 0; i < count; i++)
            send_value(pick_value());
    endtask

    // Random inserts offered as fast as the block takes them.
    task automatic test_random_back_to_back(input int count);
        int i;
        idle_enabled = 1'b0;
        for (i = 0; i < count; i++)
            send_value(pick_value());
    endtask

    // Compare each strobed result with the oldest expected entry.
    always @(posedge clk)
    begin
        listing_entry_t want;
        if (rst_n && strobe)
        begin
            if (expected_listing.size() == 0)
                report_mismatch($sformatf("result with nothing pending: value %0d pos %0d",
                                          sorted_value, position));
            else
            begin
                want = expected_listing.pop_front();
                result_count++;
                if (sorted_value !== want.sorted_value)
                    report_mismatch($sformatf("sorted_value expected %0d got %0d",
                                              want.sorted_value, sorted_value));
                if (position !== want.position)
                    report_mismatch($sformatf("position expected %0d got %0d",
                                              want.position, position));
                if (last !== want.last)
                    report_mismatch($sformatf("last expected %0b got %0b at pos %0d",
                                              want.last, last, want.position));
                if (overflow !== want.overflow)
                    report_mismatch($sformatf("overflow expected %0b got %0b at pos %0d",
                                              want.overflow, overflow, want.position));
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_listing.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_extremes();
        test_full_list_drops();
        test_random_with_gaps(200);
        test_random_back_to_back(100);

        // drop start, drain the pending listings, then watch for stray strobes
        start <= 1'b0;
        while (expected_listing.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Covered %0d inserts from empty to full and past it, %0d listed values checked,",
                 insert_count, result_count);
        $display("%0d listings dropped a value; %0d mismatches.", overflow_listings, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sorted_insert_list.f =====
hdl/sil_pkg.sv
hdl/sil_ram.sv
hdl/sorted_insert_list.sv
tb/sorted_insert_list_test.sv
